>>> rtl/core/pfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_pkg: shared constants and types for the plane-from-three-points block
// Widths of the cross product and offset stages follow from CoordBits.
// ----------------------------------------------------------------------------
package pfp_pkg;

  localparam int CoordBits  = 16;
  localparam int PreShift   = (CoordBits > 29) ? CoordBits - 29 : 0;
  localparam int EdgeBits   = CoordBits + 1 - PreShift;
  localparam int ProdBits   = 2 * EdgeBits;
  localparam int MagBits    = ProdBits + 1;
  localparam int ShBits     = $clog2(MagBits + 1);
  localparam int NormBits   = 30;
  localparam int SumBits    = 2 * NormBits + 2;
  localparam int RootBits   = NormBits + 1;
  localparam int RootSteps  = SumBits / 2;
  localparam int QuotBits   = 15;
  localparam int FracBits   = 14;
  localparam int NumBits    = NormBits + FracBits + 1;
  localparam int NormalBits = 16;
  localparam int OffsetBits = 17;
  localparam int DotBits    = CoordBits + NormalBits + 2;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic [NormBits-1:0]         norm_t;

  // magnitudes and signs of the cross product, with the first point
  typedef struct packed {
    coord_t [2:0]              p;
    logic [2:0][MagBits-1:0]   mag;
    logic [2:0]                neg;
    logic [MagBits-1:0]        m;
  } cross_t;

  // per-item data carried alongside the root and divide pipelines
  typedef struct packed {
    coord_t [2:0] p;
    norm_t [2:0]  a;
    logic [2:0]   neg;
    logic         degen;
  } side_t;

  // magnitude shift toward zero, sign kept apart
  function automatic logic signed [EdgeBits-1:0] prescale(input logic signed [CoordBits:0] x);
    logic [CoordBits:0] mx;
    logic [CoordBits:0] sh;
    mx = x[CoordBits] ? (CoordBits + 1)'(-x) : (CoordBits + 1)'(x);
    sh = mx >> PreShift;
    return x[CoordBits] ? -sh[EdgeBits-1:0] : sh[EdgeBits-1:0];
  endfunction

endpackage

>>> rtl/core/pfp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_in_if: input channel, three points per beat
// Valid/ready handshake with nine signed coordinates.
// ----------------------------------------------------------------------------
interface pfp_in_if import pfp_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t p_x, p_y, p_z;
  coord_t q_x, q_y, q_z;
  coord_t r_x, r_y, r_z;

  modport source (output valid, p_x, p_y, p_z, q_x, q_y, q_z, r_x, r_y, r_z,
                  input ready);
  modport sink   (input valid, p_x, p_y, p_z, q_x, q_y, q_z, r_x, r_y, r_z,
                  output ready);
endinterface

>>> rtl/core/pfp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_out_if: output channel, one plane per beat
// Valid/ready handshake with unit normal, offset and degenerate flag.
// ----------------------------------------------------------------------------
interface pfp_out_if import pfp_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [NormalBits-1:0] normal_x, normal_y, normal_z;
  logic signed [OffsetBits-1:0] plane_offset;
  logic                         degenerate;

  modport source (output valid, normal_x, normal_y, normal_z, plane_offset, degenerate,
                  input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, plane_offset, degenerate,
                  output ready);
endinterface

>>> rtl/core/plane_from_three_points.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plane_from_three_points: unit normal and offset of the plane through P, Q, R
// Top level: cross product, normalize, root, divide, offset, output register.
// ----------------------------------------------------------------------------
// Fully pipelined: one triangle is accepted every clock while the output is
// taken, and each result passes through 3 cross product stages, 4 normalize
// stages, 31 square-root stages, 15 divide stages, 1 offset stage and the
// output register. The whole pipeline advances together, so it holds in place
// while a result waits on the output.
// Collinear or repeated points give a zero normal and offset with the
// degenerate flag set.
module plane_from_three_points import pfp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  pfp_in_if.sink   in_i,
  pfp_out_if.source out_o
);

  logic                     en;
  logic                     out_valid_q;
  coord_t [2:0]             p_in, q_in, r_in;

  logic                     cr_valid, nm_valid, sq_valid, dv_valid;
  cross_t                   cr_data;
  side_t                    nm_side, sq_side, dv_side;
  logic [SumBits-1:0]       nm_sum;
  logic [RootBits-1:0]      sq_len;
  logic [2:0][QuotBits-1:0] dv_quot;

  logic                                   f1_valid_q;
  logic                                   f1_degen_q;
  logic signed [NormalBits-1:0]           n_d [3], n_q [3];
  logic signed [NormalBits+CoordBits-1:0] prod_d [3], prod_q [3];
  logic [NormalBits-1:0]                  nq;

  logic signed [DotBits-1:0]              dot;
  logic signed [DotBits:0]                dotx, rnd, dsh;
  logic signed [OffsetBits-1:0]           off_d;

  localparam logic signed [DotBits:0] Half   = (DotBits + 1)'(1) << (FracBits - 1);
  localparam logic signed [DotBits:0] OffMax = (DotBits + 1)'((1 << (OffsetBits - 1)) - 1);
  localparam logic signed [DotBits:0] OffMin = -((DotBits + 1)'(1) << (OffsetBits - 1));

  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;
  assign out_o.valid = out_valid_q;

  assign p_in = {in_i.p_z, in_i.p_y, in_i.p_x};
  assign q_in = {in_i.q_z, in_i.q_y, in_i.q_x};
  assign r_in = {in_i.r_z, in_i.r_y, in_i.r_x};

  pfp_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .p_i     (p_in),
    .q_i     (q_in),
    .r_i     (r_in),
    .valid_o (cr_valid),
    .cross_o (cr_data)
  );

  pfp_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cr_valid),
    .cross_i (cr_data),
    .valid_o (nm_valid),
    .side_o  (nm_side),
    .sum_o   (nm_sum)
  );

  pfp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (nm_valid),
    .side_i  (nm_side),
    .sum_i   (nm_sum),
    .valid_o (sq_valid),
    .side_o  (sq_side),
    .len_o   (sq_len)
  );

  pfp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .side_i  (sq_side),
    .len_i   (sq_len),
    .valid_o (dv_valid),
    .side_o  (dv_side),
    .quot_o  (dv_quot)
  );

  // signed normal and its products with P
  always_comb begin
    nq = '0;
    for (int i = 0; i < 3; i++) begin
      nq        = {1'b0, dv_quot[i]};
      n_d[i]    = dv_side.neg[i] ? $signed(-nq) : $signed(nq);
      prod_d[i] = n_d[i] * $signed(dv_side.p[i]);
    end
  end

  // offset: round to nearest, ties up, then saturate
  always_comb begin
    dot  = DotBits'(prod_q[0]) + DotBits'(prod_q[1]) + DotBits'(prod_q[2]);
    dotx = {dot[DotBits-1], dot};
    rnd  = Half - dotx;
    dsh  = rnd >>> FracBits;
    if (dsh > OffMax) begin
      off_d = OffMax[OffsetBits-1:0];
    end else if (dsh < OffMin) begin
      off_d = OffMin[OffsetBits-1:0];
    end else begin
      off_d = dsh[OffsetBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      f1_valid_q  <= dv_valid;
      out_valid_q <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_q        <= n_d;
      prod_q     <= prod_d;
      f1_degen_q <= dv_side.degen;
      out_o.degenerate <= f1_degen_q;
      if (f1_degen_q) begin
        out_o.normal_x     <= '0;
        out_o.normal_y     <= '0;
        out_o.normal_z     <= '0;
        out_o.plane_offset <= '0;
      end else begin
        out_o.normal_x     <= n_q[0];
        out_o.normal_y     <= n_q[1];
        out_o.normal_z     <= n_q[2];
        out_o.plane_offset <= off_d;
      end
    end
  end

`ifndef SYNTH
  // a unit normal never leaves [-1, 1] in Q2.14
  a_normal_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.normal_x <= 16'sd16384 && out_o.normal_x >= -16'sd16384 &&
                     out_o.normal_y <= 16'sd16384 && out_o.normal_y >= -16'sd16384 &&
                     out_o.normal_z <= 16'sd16384 && out_o.normal_z >= -16'sd16384))
    else $error("normal component out of unit range");

  // largest component of a unit normal is at least 1/sqrt(3)
  a_normal_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.degenerate |->
      (out_o.normal_x >= 16'sd9000 || out_o.normal_x <= -16'sd9000 ||
       out_o.normal_y >= 16'sd9000 || out_o.normal_y <= -16'sd9000 ||
       out_o.normal_z >= 16'sd9000 || out_o.normal_z <= -16'sd9000))
    else $error("normal too short for unit length");

  // a stalled output beat keeps the pipeline frozen
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> f1_valid_q == $past(f1_valid_q))
    else $error("pipeline moved while output stalled");
`endif

endmodule

>>> rtl/core/pfp_cross.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_cross: edge vectors and cross product
// Three stages: edges, six products, differences with magnitude and max.
// ----------------------------------------------------------------------------
module pfp_cross import pfp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  coord_t [2:0] p_i,
  input  coord_t [2:0] q_i,
  input  coord_t [2:0] r_i,
  output logic         valid_o,
  output cross_t       cross_o
);

  logic                       s1_valid_q, s2_valid_q;
  logic signed [EdgeBits-1:0] u_d [3], v_d [3], u_q [3], v_q [3];
  coord_t [2:0]               p1_q, p2_q;
  logic signed [ProdBits-1:0] pr_d [6], pr_q [6];
  logic signed [MagBits-1:0]  c_d [3];
  cross_t                     cross_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_d[i] = prescale($signed({q_i[i][CoordBits-1], q_i[i]})
                        - $signed({p_i[i][CoordBits-1], p_i[i]}));
      v_d[i] = prescale($signed({r_i[i][CoordBits-1], r_i[i]})
                        - $signed({p_i[i][CoordBits-1], p_i[i]}));
    end
  end

  always_comb begin
    pr_d[0] = u_q[1] * v_q[2];
    pr_d[1] = u_q[2] * v_q[1];
    pr_d[2] = u_q[2] * v_q[0];
    pr_d[3] = u_q[0] * v_q[2];
    pr_d[4] = u_q[0] * v_q[1];
    pr_d[5] = u_q[1] * v_q[0];
  end

  always_comb begin
    cross_d   = '0;
    cross_d.p = p2_q;
    for (int i = 0; i < 3; i++) begin
      c_d[i] = $signed({pr_q[2*i][ProdBits-1], pr_q[2*i]})
               - $signed({pr_q[2*i+1][ProdBits-1], pr_q[2*i+1]});
      cross_d.neg[i] = c_d[i][MagBits-1];
      cross_d.mag[i] = c_d[i][MagBits-1] ? MagBits'(-c_d[i]) : MagBits'(c_d[i]);
    end
    cross_d.m = cross_d.mag[0];
    if (cross_d.mag[1] > cross_d.m) cross_d.m = cross_d.mag[1];
    if (cross_d.mag[2] > cross_d.m) cross_d.m = cross_d.mag[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      valid_o    <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      valid_o    <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q     <= u_d;
      v_q     <= v_d;
      p1_q    <= p_i;
      pr_q    <= pr_d;
      p2_q    <= p1_q;
      cross_o <= cross_d;
    end
  end

endmodule

>>> rtl/core/pfp_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_norm: block normalization and sum of squares
// Leading-one search, common shift into [2^29, 2^30), squares, sum.
// ----------------------------------------------------------------------------
module pfp_norm import pfp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  cross_t             cross_i,
  output logic               valid_o,
  output side_t              side_o,
  output logic [SumBits-1:0] sum_o
);

  logic                        a_valid_q, b_valid_q, c_valid_q;
  logic [ShBits-1:0]           sh_d, sh_q;
  cross_t                      cr_q;
  logic                        degen_q;
  side_t                       side_b_d, side_b_q, side_c_q;
  logic [MagBits+NormBits-1:0] wide [3];
  logic [2*NormBits-1:0]       sq_d [3], sq_q [3];

  // shift right by msb+1 of {mag, zeros} lands the max in [2^29, 2^30)
  always_comb begin
    sh_d = '0;
    for (int i = 0; i < MagBits; i++) begin
      if (cross_i.m[i]) sh_d = ShBits'(i + 1);
    end
  end

  always_comb begin
    side_b_d       = '0;
    side_b_d.p     = cr_q.p;
    side_b_d.neg   = cr_q.neg;
    side_b_d.degen = degen_q;
    for (int i = 0; i < 3; i++) begin
      wide[i]       = {cr_q.mag[i], {NormBits{1'b0}}} >> sh_q;
      side_b_d.a[i] = wide[i][NormBits-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) sq_d[i] = side_b_q.a[i] * side_b_q.a[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      valid_o   <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      valid_o   <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sh_q     <= sh_d;
      cr_q     <= cross_i;
      degen_q  <= (cross_i.m == '0);
      side_b_q <= side_b_d;
      sq_q     <= sq_d;
      side_c_q <= side_b_q;
      side_o   <= side_c_q;
      sum_o    <= SumBits'(sq_q[0]) + SumBits'(sq_q[1]) + SumBits'(sq_q[2]);
    end
  end

endmodule

>>> rtl/core/pfp_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_sqrt: pipelined integer square root
// One result bit per stage, digit-by-digit method, floor of the root.
// ----------------------------------------------------------------------------
module pfp_sqrt import pfp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  side_t               side_i,
  input  logic [SumBits-1:0]  sum_i,
  output logic                valid_o,
  output side_t               side_o,
  output logic [RootBits-1:0] len_o
);

  logic               vld_q  [RootSteps];
  side_t              side_q [RootSteps];
  logic [SumBits-1:0] rem_q  [RootSteps];
  logic [SumBits-1:0] res_q  [RootSteps];

  for (genvar j = 0; j < RootSteps; j++) begin : g_step
    localparam logic [SumBits-1:0] StepBit = SumBits'(1) << (2 * (RootSteps - 1 - j));
    logic               vin;
    side_t              sin;
    logic [SumBits-1:0] rem_in, res_in;
    logic [SumBits:0]   trial;

    if (j == 0) begin : g_first
      assign vin    = valid_i;
      assign sin    = side_i;
      assign rem_in = sum_i;
      assign res_in = '0;
    end else begin : g_next
      assign vin    = vld_q[j-1];
      assign sin    = side_q[j-1];
      assign rem_in = rem_q[j-1];
      assign res_in = res_q[j-1];
    end

    assign trial = {1'b0, res_in} + {1'b0, StepBit};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[j] <= sin;
        if ({1'b0, rem_in} >= trial) begin
          rem_q[j] <= rem_in - trial[SumBits-1:0];
          res_q[j] <= (res_in >> 1) + StepBit;
        end else begin
          rem_q[j] <= rem_in;
          res_q[j] <= res_in >> 1;
        end
      end
    end
  end

  assign valid_o = vld_q[RootSteps-1];
  assign side_o  = side_q[RootSteps-1];
  assign len_o   = res_q[RootSteps-1][RootBits-1:0];

endmodule

>>> rtl/core/pfp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfp_div: pipelined rounded divide, three lanes
// q = (a * 2^14 + len/2) / len, one quotient bit per stage.
// ----------------------------------------------------------------------------
module pfp_div import pfp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  side_t                    side_i,
  input  logic [RootBits-1:0]      len_i,
  output logic                     valid_o,
  output side_t                    side_o,
  output logic [2:0][QuotBits-1:0] quot_o
);

  logic                     vld_q  [QuotBits];
  side_t                    side_q [QuotBits];
  logic [RootBits-1:0]      len_q  [QuotBits];
  logic [2:0][NumBits-1:0]  rem_q  [QuotBits];
  logic [2:0][QuotBits-1:0] quo_q  [QuotBits];

  for (genvar j = 0; j < QuotBits; j++) begin : g_step
    localparam int Sh = QuotBits - 1 - j;
    logic                     vin;
    side_t                    sin;
    logic [RootBits-1:0]      lin;
    logic [2:0][NumBits-1:0]  rem_in, rem_d;
    logic [2:0][QuotBits-1:0] quo_in, quo_d;
    logic [NumBits-1:0]       dvs;

    if (j == 0) begin : g_first
      assign vin = valid_i;
      assign sin = side_i;
      assign lin = len_i;
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = NumBits'({side_i.a[i], {FracBits{1'b0}}}) + NumBits'(len_i >> 1);
        end
      end
      assign quo_in = '0;
    end else begin : g_next
      assign vin    = vld_q[j-1];
      assign sin    = side_q[j-1];
      assign lin    = len_q[j-1];
      assign rem_in = rem_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    assign dvs = NumBits'(lin) << Sh;

    always_comb begin
      rem_d = rem_in;
      quo_d = quo_in;
      for (int i = 0; i < 3; i++) begin
        if (rem_in[i] >= dvs) begin
          rem_d[i]     = rem_in[i] - dvs;
          quo_d[i][Sh] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[j] <= sin;
        len_q[j]  <= lin;
        rem_q[j]  <= rem_d;
        quo_q[j]  <= quo_d;
      end
    end
  end

  assign valid_o = vld_q[QuotBits-1];
  assign side_o  = side_q[QuotBits-1];
  assign quot_o  = quo_q[QuotBits-1];

endmodule
